### design/tpp_pkg.sv
// Shared types, constants and configuration defaults for the tilted pinhole projection.
`default_nettype none
package tpp_pkg;

  localparam int CW   = 32;          // coordinate width
  localparam int RW   = CW - 1;      // unsigned register width
  localparam int TW   = 16;          // trig width
  localparam int FRAC = TW - 2;      // trig fraction bits
  localparam int MW   = CW + 1;      // difference width
  localparam int PW   = MW + TW;     // first products
  localparam int SW   = PW + 1;      // sums of products
  localparam int XW   = MW + FRAC;   // scaled x numerator base
  localparam int MLW  = 17;          // low split of the second factor
  localparam int QW   = CW + 2;      // quotient bits kept
  localparam int DW   = SW;          // divisor magnitude
  localparam int NW   = DW + QW;     // numerator width
  localparam int OW   = QW + 2;      // signed result with offset
  localparam int IW   = 3;           // register index width

  typedef enum logic [IW-1:0] {
    REG_ALTITUDE = 3'd0,
    REG_FOCAL    = 3'd1,
    REG_CENTER_X = 3'd2,
    REG_CENTER_Y = 3'd3,
    REG_COS_TILT = 3'd4,
    REG_SIN_TILT = 3'd5
  } reg_idx_e;

  localparam logic [RW-1:0] ALTITUDE_RST = RW'(196608000);
  localparam logic [RW-1:0] FOCAL_RST    = RW'(65536000);
  localparam logic [RW-1:0] CENTER_X_RST = RW'(20971520);
  localparam logic [RW-1:0] CENTER_Y_RST = RW'(15728640);
  localparam logic [TW-1:0] COS_RST      = TW'(1 << FRAC);
  localparam logic [TW-1:0] SIN_RST      = '0;

  typedef struct packed {
    logic                 opcode;
    logic signed [CW-1:0] in_x;
    logic signed [CW-1:0] in_y;
    logic signed [CW-1:0] in_z;
  } in_t;

  typedef struct packed {
    logic signed [CW-1:0] out_x;
    logic signed [CW-1:0] out_y;
    logic signed [CW-1:0] out_z;
    logic                 status;
  } out_t;

  typedef struct packed {
    logic [RW-1:0]        altitude;
    logic [RW-1:0]        focal_scale;
    logic [RW-1:0]        center_x;
    logic [RW-1:0]        center_y;
    logic signed [TW-1:0] cos_tilt;
    logic signed [TW-1:0] sin_tilt;
  } cfg_t;

  typedef struct packed {
    logic                 op;
    logic                 bad;
    logic signed [CW-1:0] z;
  } side_t;

  typedef struct packed {
    side_t                side;
    logic signed [SW-1:0] d;
    logic signed [NW-1:0] nx;
    logic signed [NW-1:0] ny;
  } mid_t;

  typedef struct packed {
    side_t         side;
    logic [DW-1:0] ad;
    logic          negx;
    logic          negy;
    logic          ovfx;
    logic          ovfy;
    logic [DW-1:0] remx;
    logic [DW-1:0] remy;
    logic [QW-1:0] lowx;
    logic [QW-1:0] lowy;
    logic [QW-1:0] qx;
    logic [QW-1:0] qy;
  } div_t;

endpackage
`default_nettype wire

### design/tilted_pinhole_projection.sv
// Tilted pinhole projection: top level with configuration registers and pipeline.
// Throughput: one word per cycle while the output is not stalled; the 34-stage restoring divider sets the depth.
// The whole pipeline halts while the output word is held by out_stall_i.
// Reset clears all valid bits and loads the default configuration.
`default_nettype none
module tilted_pinhole_projection (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire tpp_pkg::in_t                in_word_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output tpp_pkg::out_t                    out_word_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [tpp_pkg::IW-1:0]      cfg_idx_i,
  input  wire logic [tpp_pkg::RW-1:0]      cfg_wdata_i
);

  tpp_pkg::cfg_t cfg_q;
  logic          adv;
  logic          fr_v, nm_v, dv_v;
  tpp_pkg::mid_t fr_mid;
  tpp_pkg::div_t nm_div, dv_div;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{altitude:    tpp_pkg::ALTITUDE_RST,
                 focal_scale: tpp_pkg::FOCAL_RST,
                 center_x:    tpp_pkg::CENTER_X_RST,
                 center_y:    tpp_pkg::CENTER_Y_RST,
                 cos_tilt:    tpp_pkg::COS_RST,
                 sin_tilt:    tpp_pkg::SIN_RST};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tpp_pkg::REG_ALTITUDE: cfg_q.altitude    <= cfg_wdata_i;
        tpp_pkg::REG_FOCAL:    cfg_q.focal_scale <= cfg_wdata_i;
        tpp_pkg::REG_CENTER_X: cfg_q.center_x    <= cfg_wdata_i;
        tpp_pkg::REG_CENTER_Y: cfg_q.center_y    <= cfg_wdata_i;
        tpp_pkg::REG_COS_TILT: cfg_q.cos_tilt    <= cfg_wdata_i[tpp_pkg::TW-1:0];
        tpp_pkg::REG_SIN_TILT: cfg_q.sin_tilt    <= cfg_wdata_i[tpp_pkg::TW-1:0];
        default: ;
      endcase
    end
  end

  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  tpp_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (in_valid_i),
    .word_i  (in_word_i),
    .cfg_i   (cfg_q),
    .valid_o (fr_v),
    .mid_o   (fr_mid)
  );

  tpp_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (fr_v),
    .mid_i   (fr_mid),
    .valid_o (nm_v),
    .div_o   (nm_div)
  );

  tpp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (nm_v),
    .div_i   (nm_div),
    .valid_o (dv_v),
    .div_o   (dv_div)
  );

  tpp_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (dv_v),
    .div_i   (dv_div),
    .cfg_i   (cfg_q),
    .valid_o (out_valid_o),
    .word_o  (out_word_o)
  );

`ifndef ASSERT_OFF
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status |->
      out_word_o.out_x == '0 && out_word_o.out_y == '0 && out_word_o.out_z == '0)
    else $error("degenerate word with nonzero coordinates");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_v && !dv_div.side.bad && !dv_div.ovfx && !dv_div.ovfy |->
      dv_div.remx < dv_div.ad && dv_div.remy < dv_div.ad)
    else $error("divider remainder not below divisor");

  a_hold_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while output word is held");
`endif

endmodule
`default_nettype wire

### design/tpp_front.sv
// Front end: differences, rotation products, second products and numerator sums.
`default_nettype none
module tpp_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         adv_i,
  input  wire logic         valid_i,
  input  wire tpp_pkg::in_t word_i,
  input  wire tpp_pkg::cfg_t cfg_i,
  output logic              valid_o,
  output tpp_pkg::mid_t     mid_o
);

  logic                           s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q;
  tpp_pkg::side_t                 s1_side_q, s2_side_q, s3_side_q, s4_side_q;
  tpp_pkg::side_t                 s3_side_d;
  logic signed [tpp_pkg::CW-1:0]  s1_x_q, s1_y_q;
  logic signed [tpp_pkg::MW-1:0]  s1_dz_d, s1_nu_d, s1_nv_d;
  logic signed [tpp_pkg::MW-1:0]  s1_dz_q, s1_nu_q, s1_nv_q;
  logic signed [tpp_pkg::MW-1:0]  ma, mb, fz;
  logic signed [tpp_pkg::PW-1:0]  p1_q, p2_q, p3_q, p4_q;
  logic signed [tpp_pkg::MW-1:0]  s2_xs_q, s2_mf_q, s3_mf_q;
  logic signed [tpp_pkg::XW-1:0]  s3_bx_q;
  logic signed [tpp_pkg::SW-1:0]  s3_by_d, s3_d_d, s3_by_q, s3_d_q, s4_d_q;
  logic signed [tpp_pkg::MLW:0]   ml;
  logic signed [tpp_pkg::MW-tpp_pkg::MLW-1:0] mh;
  logic signed [tpp_pkg::NW-1:0]  pxl_q, pxh_q, pyl_q, pyh_q;
  tpp_pkg::mid_t                  mid_q;

  always_comb begin
    s1_dz_d = tpp_pkg::MW'(word_i.in_z) - $signed(tpp_pkg::MW'(cfg_i.altitude));
    s1_nu_d = $signed(tpp_pkg::MW'(cfg_i.center_x)) - tpp_pkg::MW'(word_i.in_x);
    s1_nv_d = $signed(tpp_pkg::MW'(cfg_i.center_y)) - tpp_pkg::MW'(word_i.in_y);
    fz      = $signed(tpp_pkg::MW'(cfg_i.focal_scale));
    ma      = s1_side_q.op ? s1_nv_q : tpp_pkg::MW'(s1_y_q);
    mb      = s1_side_q.op ? fz : s1_dz_q;
    s3_by_d = tpp_pkg::SW'(p1_q) + tpp_pkg::SW'(p2_q);
    s3_d_d  = tpp_pkg::SW'(p3_q) - tpp_pkg::SW'(p4_q);
    s3_side_d     = s2_side_q;
    s3_side_d.bad = s2_side_q.op ? (s3_d_d == '0) : (s3_d_d[tpp_pkg::SW-1] || s3_d_d == '0);
    ml = $signed({1'b0, s3_mf_q[tpp_pkg::MLW-1:0]});
    mh = $signed(s3_mf_q[tpp_pkg::MW-1:tpp_pkg::MLW]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
    end else if (adv_i) begin
      s1_v_q <= valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      s5_v_q <= s4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_side_q <= '{op: word_i.opcode, bad: 1'b0, z: word_i.in_z};
      s1_x_q    <= word_i.in_x;
      s1_y_q    <= word_i.in_y;
      s1_dz_q   <= s1_dz_d;
      s1_nu_q   <= s1_nu_d;
      s1_nv_q   <= s1_nv_d;
      // rotation products
      s2_side_q <= s1_side_q;
      p1_q      <= cfg_i.cos_tilt * ma;
      p2_q      <= cfg_i.sin_tilt * mb;
      p3_q      <= cfg_i.sin_tilt * ma;
      p4_q      <= cfg_i.cos_tilt * mb;
      s2_xs_q   <= s1_side_q.op ? s1_nu_q : tpp_pkg::MW'(s1_x_q);
      s2_mf_q   <= s1_side_q.op ? s1_dz_q : fz;
      // numerator bases and divisor
      s3_side_q <= s3_side_d;
      s3_bx_q   <= $signed({s2_xs_q, {tpp_pkg::FRAC{1'b0}}});
      s3_by_q   <= s3_by_d;
      s3_d_q    <= s3_d_d;
      s3_mf_q   <= s2_mf_q;
      // split second products
      s4_side_q <= s3_side_q;
      s4_d_q    <= s3_d_q;
      pxl_q     <= s3_bx_q * ml;
      pxh_q     <= s3_bx_q * mh;
      pyl_q     <= s3_by_q * ml;
      pyh_q     <= s3_by_q * mh;
      // recombine
      mid_q.side <= s4_side_q;
      mid_q.d    <= s4_d_q;
      mid_q.nx   <= (pxh_q <<< tpp_pkg::MLW) + pxl_q;
      mid_q.ny   <= (pyh_q <<< tpp_pkg::MLW) + pyl_q;
    end
  end

  assign valid_o = s5_v_q;
  assign mid_o   = mid_q;

endmodule
`default_nettype wire

### design/tpp_norm.sv
// Sign and magnitude split, range check and divider set-up.
`default_nettype none
module tpp_norm (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         adv_i,
  input  wire logic         valid_i,
  input  wire tpp_pkg::mid_t mid_i,
  output logic              valid_o,
  output tpp_pkg::div_t     div_o
);

  logic                          s6_v_q, s7_v_q;
  tpp_pkg::side_t                s6_side_q;
  logic [tpp_pkg::NW-1:0]        ax_q, ay_q;
  logic [tpp_pkg::DW-1:0]        ad_q;
  logic                          negx_q, negy_q;
  tpp_pkg::div_t                 div_d, div_q;

  always_comb begin
    div_d.side = s6_side_q;
    div_d.ad   = ad_q;
    div_d.negx = negx_q;
    div_d.negy = negy_q;
    div_d.ovfx = ax_q >= {ad_q, {tpp_pkg::QW{1'b0}}};
    div_d.ovfy = ay_q >= {ad_q, {tpp_pkg::QW{1'b0}}};
    div_d.remx = ax_q[tpp_pkg::NW-1:tpp_pkg::QW];
    div_d.remy = ay_q[tpp_pkg::NW-1:tpp_pkg::QW];
    div_d.lowx = ax_q[tpp_pkg::QW-1:0];
    div_d.lowy = ay_q[tpp_pkg::QW-1:0];
    div_d.qx   = '0;
    div_d.qy   = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_v_q <= 1'b0;
      s7_v_q <= 1'b0;
    end else if (adv_i) begin
      s6_v_q <= valid_i;
      s7_v_q <= s6_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s6_side_q <= mid_i.side;
      ax_q      <= mid_i.nx[tpp_pkg::NW-1] ? unsigned'(-mid_i.nx) : unsigned'(mid_i.nx);
      ay_q      <= mid_i.ny[tpp_pkg::NW-1] ? unsigned'(-mid_i.ny) : unsigned'(mid_i.ny);
      ad_q      <= mid_i.d[tpp_pkg::SW-1] ? unsigned'(-mid_i.d) : unsigned'(mid_i.d);
      negx_q    <= mid_i.nx[tpp_pkg::NW-1] ^ mid_i.d[tpp_pkg::SW-1];
      negy_q    <= mid_i.ny[tpp_pkg::NW-1] ^ mid_i.d[tpp_pkg::SW-1];
      div_q     <= div_d;
    end
  end

  assign valid_o = s7_v_q;
  assign div_o   = div_q;

endmodule
`default_nettype wire

### design/tpp_div.sv
// Pipelined restoring divider, one quotient bit per stage for both lanes.
`default_nettype none
module tpp_div (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         adv_i,
  input  wire logic         valid_i,
  input  wire tpp_pkg::div_t div_i,
  output logic              valid_o,
  output tpp_pkg::div_t     div_o
);

  logic                 v_q  [tpp_pkg::QW];
  tpp_pkg::div_t        st_q [tpp_pkg::QW];
  tpp_pkg::div_t        st_d [tpp_pkg::QW];

  function automatic logic [tpp_pkg::DW:0] step(input logic [tpp_pkg::DW-1:0] rem,
                                                input logic                   bit_in,
                                                input logic [tpp_pkg::DW-1:0] ad);
    logic [tpp_pkg::DW:0] trial;
    logic                 ge;
    trial = {rem, bit_in};
    ge    = trial >= {1'b0, ad};
    if (ge) begin
      trial = trial - {1'b0, ad};
    end
    return {ge, trial[tpp_pkg::DW-1:0]};
  endfunction

  for (genvar k = 0; k < tpp_pkg::QW; k++) begin : g_stage
    tpp_pkg::div_t        src;
    logic [tpp_pkg::DW:0] rx, ry;
    logic                 src_v;

    if (k == 0) begin : g_first
      assign src   = div_i;
      assign src_v = valid_i;
    end else begin : g_next
      assign src   = st_q[k-1];
      assign src_v = v_q[k-1];
    end

    always_comb begin
      rx = step(src.remx, src.lowx[tpp_pkg::QW-1], src.ad);
      ry = step(src.remy, src.lowy[tpp_pkg::QW-1], src.ad);
      st_d[k]      = src;
      st_d[k].remx = rx[tpp_pkg::DW-1:0];
      st_d[k].remy = ry[tpp_pkg::DW-1:0];
      st_d[k].lowx = {src.lowx[tpp_pkg::QW-2:0], 1'b0};
      st_d[k].lowy = {src.lowy[tpp_pkg::QW-2:0], 1'b0};
      st_d[k].qx   = {src.qx[tpp_pkg::QW-2:0], rx[tpp_pkg::DW]};
      st_d[k].qy   = {src.qy[tpp_pkg::QW-2:0], ry[tpp_pkg::DW]};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (adv_i) begin
        v_q[k] <= src_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign valid_o = v_q[tpp_pkg::QW-1];
  assign div_o   = st_q[tpp_pkg::QW-1];

endmodule
`default_nettype wire

### design/tpp_back.sv
// Sign restore, centre offset, saturation and output register.
`default_nettype none
module tpp_back (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         adv_i,
  input  wire logic         valid_i,
  input  wire tpp_pkg::div_t div_i,
  input  wire tpp_pkg::cfg_t cfg_i,
  output logic              valid_o,
  output tpp_pkg::out_t     word_o
);

  logic          v_q;
  tpp_pkg::out_t word_d, word_q;
  logic [tpp_pkg::RW-1:0] offx, offy;

  function automatic logic signed [tpp_pkg::CW-1:0] finish(input logic [tpp_pkg::QW-1:0] q,
                                                           input logic neg,
                                                           input logic ovf,
                                                           input logic [tpp_pkg::RW-1:0] off);
    logic signed [tpp_pkg::OW-1:0] qs;
    logic signed [tpp_pkg::OW-1:0] sum;
    logic signed [tpp_pkg::CW-1:0] res;
    qs  = neg ? -$signed(tpp_pkg::OW'(q)) : $signed(tpp_pkg::OW'(q));
    sum = qs + $signed(tpp_pkg::OW'(off));
    if (ovf) begin
      res = neg ? {1'b1, {(tpp_pkg::CW-1){1'b0}}} : {1'b0, {(tpp_pkg::CW-1){1'b1}}};
    end else if (sum[tpp_pkg::OW-1:tpp_pkg::CW-1] == '0 ||
                 sum[tpp_pkg::OW-1:tpp_pkg::CW-1] == '1) begin
      res = sum[tpp_pkg::CW-1:0];
    end else begin
      res = sum[tpp_pkg::OW-1] ? {1'b1, {(tpp_pkg::CW-1){1'b0}}}
                               : {1'b0, {(tpp_pkg::CW-1){1'b1}}};
    end
    return res;
  endfunction

  always_comb begin
    offx = div_i.side.op ? '0 : cfg_i.center_x;
    offy = div_i.side.op ? '0 : cfg_i.center_y;
    if (div_i.side.bad) begin
      word_d = '{out_x: '0, out_y: '0, out_z: '0, status: 1'b1};
    end else begin
      word_d.out_x  = finish(div_i.qx, div_i.negx, div_i.ovfx, offx);
      word_d.out_y  = finish(div_i.qy, div_i.negy, div_i.ovfy, offy);
      word_d.out_z  = div_i.side.op ? div_i.side.z : '0;
      word_d.status = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (adv_i) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = v_q;
  assign word_o  = word_q;

endmodule
`default_nettype wire
